// ===== hw/rtl/rdc_pkg.sv =====
// Shared constants, types and helper functions of the radix digit converter.
package rdc_pkg;

	// Default width of the value word.
	localparam int VALUE_BITS_DEF = 31;

	// Field widths.
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W = 7;

	// Quotient bits the divider settles per cycle.
	localparam int STEP_BITS = 8;

	// Legal radix range; other codes saturate to the nearer bound.
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	// ASCII codes of the digit alphabet.
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_A = 7'd65;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

	// Header of a queued job: valid flag and the already saturated radix.
	typedef struct packed {
		logic               valid;
		logic [RADIX_W-1:0] radix;
	} job_hdr_t;

	// Clamp a radix code into the legal range.
	function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] s;
		if (r < RADIX_MIN) begin
			s = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			s = RADIX_MAX;
		end else begin
			s = r;
		end
		return s;
	endfunction

	// Map a digit to its ASCII character, 0-9 then A-F.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
		end else begin
			c = CHAR_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DIGIT_TEN};
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/rdc_front.sv =====
// Front end: accepts words, saturates the radix and queues jobs for the back end.
module rdc_front #(
	parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [VALUE_BITS-1:0]        value,
	input  logic [rdc_pkg::RADIX_W-1:0]  radix,
	output rdc_pkg::job_hdr_t            job_hdr,
	output logic [VALUE_BITS-1:0]        job_value,
	input  logic                         job_take
);

	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	logic [VALUE_BITS-1:0]       val_q [2];
	logic [rdc_pkg::RADIX_W-1:0] rad_q [2];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  cnt_q;
	logic                        accept;
	logic                        take;

	// Handshake on both sides of the job queue.
	assign full   = (cnt_q == QUEUE_DEPTH);
	assign accept = push && !full;
	assign take   = job_take && (cnt_q != 2'd0);

	// Head of the queue toward the back end.
	assign job_hdr.valid = (cnt_q != 2'd0);
	assign job_hdr.radix = rad_q[rd_ptr_q];
	assign job_value     = val_q[rd_ptr_q];

	// Queue storage; the radix is stored already clamped.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q[wr_ptr_q] <= value;
			rad_q[wr_ptr_q] <= rdc_pkg::sat_radix(radix);
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({accept, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rdc_back.sv =====
// Back end: iterative divider, digit memory and most-significant-first character output.
module rdc_back #(
	parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rdc_pkg::job_hdr_t            job_hdr,
	input  logic [VALUE_BITS-1:0]        job_value,
	output logic                         job_take,
	output logic                         empty,
	input  logic                         pop,
	output logic [rdc_pkg::CHAR_W-1:0]   digit_char,
	output logic                         last
);

	localparam int NCHUNK = (VALUE_BITS + rdc_pkg::STEP_BITS - 1) / rdc_pkg::STEP_BITS;
	localparam int PW = NCHUNK * rdc_pkg::STEP_BITS;
	localparam int CW = $clog2(VALUE_BITS + 1);
	localparam int IW = $clog2(VALUE_BITS);
	localparam int KW = $clog2(NCHUNK + 1);
	localparam logic [KW-1:0] LAST_CHUNK = KW'(NCHUNK - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                       state_q;
	logic [KW-1:0]                chunk_q;
	logic [CW-1:0]                cnt_q;
	logic [IW-1:0]                rd_q;
	logic [PW-1:0]                sh_q;
	logic [rdc_pkg::DIGIT_W-1:0]  rem_q;
	logic [rdc_pkg::RADIX_W-1:0]  radix_q;
	logic [rdc_pkg::DIGIT_W-1:0]  digit_store [VALUE_BITS];
	logic                         rd_v_s1;
	logic [rdc_pkg::DIGIT_W-1:0]  digit_s1;
	logic                         last_s1;
	logic                         out_valid_q;
	logic [rdc_pkg::CHAR_W-1:0]   out_char_q;
	logic                         out_last_q;
	logic [PW-1:0]                sh_nx;
	logic [rdc_pkg::DIGIT_W-1:0]  rem_nx;
	logic                         start;
	logic                         digit_done;
	logic                         load2;
	logic                         adv1;

	assign job_take   = (state_q == ST_IDLE);
	assign start      = (state_q == ST_IDLE) && job_hdr.valid;
	assign digit_done = (state_q == ST_DIV) && (chunk_q == LAST_CHUNK);

	// Output pipeline: read stage feeds the output register.
	assign load2 = rd_v_s1 && (!out_valid_q || pop);
	assign adv1  = !rd_v_s1 || load2;

	assign empty      = !out_valid_q;
	assign digit_char = out_char_q;
	assign last       = out_last_q;

	// One slice of restoring division: STEP_BITS quotient bits per cycle.
	always_comb begin
		logic [rdc_pkg::RADIX_W-1:0] part;
		logic [rdc_pkg::DIGIT_W-1:0] rem;
		logic [PW-1:0]               sh;
		rem = rem_q;
		sh  = sh_q;
		for (int i = 0; i < rdc_pkg::STEP_BITS; i++) begin
			part = {rem, sh[PW-1]};
			sh   = {sh[PW-2:0], 1'b0};
			if (part >= radix_q) begin
				part  = part - radix_q;
				sh[0] = 1'b1;
			end
			rem = part[rdc_pkg::DIGIT_W-1:0];
		end
		rem_nx = rem;
		sh_nx  = sh;
	end

	// Sequencer, counters and pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			cnt_q       <= '0;
			rd_q        <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
						chunk_q <= '0;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (chunk_q == LAST_CHUNK) begin
						chunk_q <= '0;
						cnt_q   <= cnt_q + CW'(1);
						if (sh_nx == '0) begin
							state_q <= ST_EMIT;
							rd_q    <= cnt_q[IW-1:0];
						end
					end else begin
						chunk_q <= chunk_q + KW'(1);
					end
				end
				ST_EMIT: begin
					if (adv1) begin
						rd_q <= rd_q - IW'(1);
						if (rd_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (adv1) begin
				rd_v_s1 <= (state_q == ST_EMIT);
			end
			if (load2) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divider working registers; the remainder restarts for each digit.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q    <= PW'(job_value);
			rem_q   <= '0;
			radix_q <= job_hdr.radix;
		end else if (state_q == ST_DIV) begin
			sh_q  <= sh_nx;
			rem_q <= digit_done ? '0 : rem_nx;
		end
	end

	// Digit memory: written least significant first, read back in reverse.
	always_ff @(posedge clk) begin
		if (digit_done) begin
			digit_store[cnt_q[IW-1:0]] <= rem_nx;
		end
		if ((state_q == ST_EMIT) && adv1) begin
			digit_s1 <= digit_store[rd_q];
			last_s1  <= (rd_q == '0);
		end
	end

	// Output register holding the word on offer.
	always_ff @(posedge clk) begin
		if (load2) begin
			out_char_q <= rdc_pkg::digit_to_ascii(digit_s1);
			out_last_q <= last_s1;
		end
	end

endmodule

// ===== hw/rtl/radix_digit_converter.sv =====
// Top level of the radix digit converter.
//
// Input channel: a word carries value and radix and is taken when push is high
// and full is low. Up to two words wait in a front queue while the back end works.
// A radix below 2 is treated as 2 and one above 16 as 16.
// Output channel: one word per ASCII digit, most significant first, offered
// while empty is low and taken when pop is high; last marks the final digit.
// A value of zero gives the single character '0'.
// Timing: each digit takes a full pass of the shared divider over the value,
// which settles eight quotient bits per cycle. A word is divided digit by digit
// into the digit memory, and its characters are then read back through a read stage
// and the output register, one character per cycle while pop stays high. The back end
// handles one word at a time; the next word is taken in the idle state that follows
// the read of the previous word's last digit, and only then starts dividing.
// Reset clears the queue, the sequencer and the output valid flag; the digit
// memory is not cleared. When the receiver stalls, the offered word holds and
// the back end and then the front queue fill and raise full.
module radix_digit_converter #(
	parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [VALUE_BITS-1:0]        value,
	input  logic [rdc_pkg::RADIX_W-1:0]  radix,
	output logic                         empty,
	input  logic                         pop,
	output logic [rdc_pkg::CHAR_W-1:0]   digit_char,
	output logic                         last
);

	rdc_pkg::job_hdr_t      job_hdr;
	logic [VALUE_BITS-1:0]  job_value;
	logic                   job_take;

	// Front end and job queue.
	rdc_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.radix     (radix),
		.job_hdr   (job_hdr),
		.job_value (job_value),
		.job_take  (job_take)
	);

	// Divider and character output.
	rdc_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_hdr    (job_hdr),
		.job_value  (job_value),
		.job_take   (job_take),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

// ===== hw/rtl/rdc_checker.sv =====
// Port-level checks of the radix digit converter and their bind to the top level.
module rdc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        full,
	input logic                        empty,
	input logic                        pop,
	input logic [rdc_pkg::CHAR_W-1:0]  digit_char,
	input logic                        last
);

	// Reset leaves both queues drained.
	a_reset_state: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queue not drained during reset");

	// Every offered word is a character of the digit alphabet.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((digit_char >= rdc_pkg::CHAR_ZERO) &&
			(digit_char <= rdc_pkg::CHAR_ZERO + 7'(rdc_pkg::DIGIT_NINE))) ||
			((digit_char >= rdc_pkg::CHAR_A) &&
			(digit_char <= rdc_pkg::CHAR_A + 7'(rdc_pkg::DIGIT_FIVE))))
		else $error("digit character out of range");

	// Digits of one number follow without a gap once the first is out.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last |=> !empty)
		else $error("gap inside a digit string");

	// A stalled word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(digit_char) && $stable(last))
		else $error("offered word changed while stalled");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.digit_char (digit_char),
	.last       (last)
);

// ===== tb/tb.sv =====
// Testbench of the radix digit converter: random and directed words, predicted digit strings.
module tb;

	localparam int VB = rdc_pkg::VALUE_BITS_DEF;
	localparam int HALF_PERIOD = 6;
	localparam int RANDOM_WORDS = 350;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES = 500;
	localparam int HOLD_AFTER = 40;

	// One input word and one output character.
	typedef struct packed {
		logic [VB-1:0]               val;
		logic [rdc_pkg::RADIX_W-1:0] rdx;
	} conv_word_t;

	typedef struct packed {
		logic [rdc_pkg::CHAR_W-1:0] ch;
		logic                       fin;
	} char_word_t;

	logic                          clk;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	logic [VB-1:0]                 value;
	logic [rdc_pkg::RADIX_W-1:0]   radix;
	logic                          empty;
	logic                          pop;
	logic [rdc_pkg::CHAR_W-1:0]    digit_char;
	logic                          last;

	conv_word_t pending_words[$];
	char_word_t expected_chars[$];
	int         words_taken;
	int         total_words;
	int         mismatch_count;
	int         hold_left;
	logic       hold_done;

	radix_digit_converter uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value(value),
		.radix(radix),
		.empty(empty),
		.pop(pop),
		.digit_char(digit_char),
		.last(last)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Expands one accepted word into its expected characters, most significant first.
	function automatic void predict_digits(input logic [VB-1:0] v_in,
		input logic [rdc_pkg::RADIX_W-1:0] r_in);
		logic [VB-1:0]               v;
		logic [VB-1:0]               base;
		logic [rdc_pkg::DIGIT_W-1:0] digs[VB];
		logic [rdc_pkg::DIGIT_W-1:0] d;
		int                          n;
		char_word_t                  w;
		v = v_in;
		n = 0;
		if (r_in < 2) begin
			base = VB'(2);
		end else if (r_in > 16) begin
			base = VB'(16);
		end else begin
			base = VB'(r_in);
		end
		// A zero value still yields one digit.
		if (v == 0) begin
			digs[0] = '0;
			n = 1;
		end else begin
			while (v != 0 && n < VB) begin
				digs[n] = rdc_pkg::DIGIT_W'(v % base);
				v = v / base;
				n++;
			end
		end
		for (int k = 0; k < n; k++) begin
			d = digs[n - 1 - k];
			if (d < 10) begin
				w.ch = rdc_pkg::CHAR_ZERO + rdc_pkg::CHAR_W'(d);
			end else begin
				w.ch = rdc_pkg::CHAR_A + rdc_pkg::CHAR_W'(d - 10);
			end
			w.fin = (k == n - 1);
			expected_chars.push_back(w);
		end
	endfunction

	// Idle percentage of each side; phase follows how far the stimulus has come.
	function automatic int run_phase();
		if (words_taken < total_words / 3) begin
			return 0;
		end else if (words_taken < (2 * total_words) / 3) begin
			return 1;
		end
		return 2;
	endfunction

	function automatic int sender_idle_pct();
		case (run_phase())
			0: begin
				return 17;
			end
			1: begin
				return 62;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (run_phase())
			0: begin
				return 62;
			end
			1: begin
				return 17;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	// Driver: offers pending words and predicts each one that is taken.
	always @(posedge clk) begin
		conv_word_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_digits(value, radix);
				words_taken++;
			end
			// A word that was refused stays on the ports.
			if (!push || !full) begin
				if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					nxt = pending_words.pop_front();
					push <= 1'b1;
					value <= nxt.val;
					radix <= nxt.rdx;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// One long receiver stall, so that the block fills and raises full.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && words_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each taken character against the oldest expectation.
	always @(posedge clk) begin
		char_word_t exp_w;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %0d last %0b", digit_char, last));
				end else begin
					exp_w = expected_chars.pop_front();
					if (digit_char !== exp_w.ch) begin
						report_mismatch($sformatf("digit_char %0d, expected %0d",
							digit_char, exp_w.ch));
					end
					if (last !== exp_w.fin) begin
						report_mismatch($sformatf("last %0b, expected %0b", last, exp_w.fin));
					end
				end
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= receiver_idle_pct());
			end
		end
	end

	// Adds one word to the stimulus.
	task automatic add_word(input logic [VB-1:0] v, input logic [rdc_pkg::RADIX_W-1:0] r);
		conv_word_t w;
		w.val = v;
		w.rdx = r;
		pending_words.push_back(w);
	endtask

	// Stimulus, reset and end of run.
	initial begin
		logic [VB-1:0]               v;
		logic [rdc_pkg::RADIX_W-1:0] r;
		int                          width;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		value = '0;
		radix = '0;
		words_taken = 0;
		mismatch_count = 0;

		// Directed words: zero, extremes of both fields, saturation and letter digits.
		add_word('0, 5'd10);
		add_word('0, 5'd0);
		add_word('0, 5'd31);
		add_word({VB{1'b1}}, 5'd2);
		add_word({VB{1'b1}}, 5'd16);
		add_word({VB{1'b1}}, 5'd31);
		add_word({VB{1'b1}}, 5'd0);
		add_word({VB{1'b1}}, 5'd1);
		add_word({VB{1'b1}}, 5'd17);
		add_word({VB{1'b1}}, 5'd3);
		add_word(VB'(1), 5'd2);
		add_word(VB'(1), 5'd16);
		add_word(VB'(15), 5'd16);
		add_word(VB'(10), 5'd16);
		add_word(31'h00ABCDEF, 5'd16);
		add_word(31'h40000000, 5'd2);
		add_word(31'h2AAAAAAA, 5'd2);
		add_word(31'h55555555, 5'd2);
		add_word(VB'(100), 5'd10);
		add_word(VB'(99), 5'd10);
		add_word(VB'(343), 5'd7);
		add_word(VB'(342), 5'd7);
		add_word(VB'(255), 5'd15);
		add_word(VB'(224), 5'd15);

		// Random words: mostly legal radices, values of random length.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			width = $urandom_range(0, VB);
			v = VB'($urandom());
			if (width < VB) begin
				v = v & ((VB'(1) << width) - VB'(1));
			end
			if ($urandom_range(0, 99) < 85) begin
				r = rdc_pkg::RADIX_W'($urandom_range(2, 16));
			end else begin
				r = rdc_pkg::RADIX_W'($urandom_range(0, 31));
			end
			add_word(v, r);
		end
		total_words = pending_words.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for all words to be taken and all characters to come back.
		while (pending_words.size() != 0 || push || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_chars.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#(2 * HALF_PERIOD * 1000000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== radix_digit_converter.f =====
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_front.sv
hw/rtl/rdc_back.sv
hw/rtl/radix_digit_converter.sv
hw/rtl/rdc_checker.sv
tb/tb.sv
